// ===== src/mspwm_pkg.sv =====
// Shared types and constants of the multichannel soft PWM block.
`default_nettype none

package mspwm_pkg;

  localparam int CHANNELS     = 8;
  localparam int CH_W         = 3;
  localparam int DUTY_W       = 7;
  localparam int PERIOD_STEPS = 100;

  localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] PHASE_TOP = DUTY_W'(PERIOD_STEPS - 1);

  typedef enum logic [2:0] {
    FN_TICK      = 3'd0,
    FN_ON        = 3'd1,
    FN_OFF       = 3'd2,
    FN_TOGGLE    = 3'd3,
    FN_SET_DUTY  = 3'd4,
    FN_READ_DUTY = 3'd5
  } func_t;

  typedef logic [CHANNELS-1:0][DUTY_W-1:0] duty_arr_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [CH_W-1:0]   channel;
    logic [DUTY_W-1:0] duty;
  } in_word_t;

  typedef struct packed {
    logic [CHANNELS-1:0] pin_levels;
    logic [CHANNELS-1:0] enabled_mask;
    logic [DUTY_W-1:0]   duty_read;
    logic [DUTY_W-1:0]   phase;
  } out_word_t;

  // Phase, active flags and pins as one group of PWM state.
  typedef struct packed {
    logic [DUTY_W-1:0]   phase;
    logic [CHANNELS-1:0] active;
    logic [CHANNELS-1:0] pins;
  } pwm_state_t;

endpackage

`default_nettype wire

// ===== src/mspwm_tick_unit.sv =====
// Next PWM state for one tick: phase step and per-channel duty compares.
`default_nettype none

module mspwm_tick_unit (
  input  wire mspwm_pkg::pwm_state_t                   cur,
  input  wire logic [mspwm_pkg::CHANNELS-1:0]          enabled,
  input  wire logic [mspwm_pkg::CHANNELS-1:0]          idle_mask,
  input  wire mspwm_pkg::duty_arr_t                    duties,
  output mspwm_pkg::pwm_state_t                        nxt
);

  logic [mspwm_pkg::DUTY_W-1:0]   phase_step;
  logic                           wrap;
  logic [mspwm_pkg::CHANNELS-1:0] act_base;

  always_comb begin
    wrap       = (cur.phase >= mspwm_pkg::PHASE_TOP);
    phase_step = wrap ? '0 : cur.phase + mspwm_pkg::DUTY_W'(1);
    act_base   = wrap ? '0 : cur.active;
    nxt.phase  = phase_step;
    nxt.active = act_base;
    nxt.pins   = cur.pins;
    // Each channel only touches its pin when its active flag changes.
    for (int c = 0; c < mspwm_pkg::CHANNELS; c++) begin
      if (enabled[c]) begin
        if (duties[c] > phase_step) begin
          if (!act_base[c]) begin
            nxt.pins[c]   = ~idle_mask[c];
            nxt.active[c] = 1'b1;
          end
        end else begin
          if (act_base[c]) begin
            nxt.pins[c]   = idle_mask[c];
            nxt.active[c] = 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/multichannel_soft_pwm_core.sv =====
// Top level of the multichannel soft PWM block: word registers and state update.
`default_nettype none

// Multichannel soft PWM core.
// The input channel (in_valid, in_stall, in_word) carries one command word:
// a tick, switch on, switch off, toggle, set duty or read duty for a channel.
// Every accepted word yields exactly one result word on the output channel
// (out_valid, out_stall, out_word) holding the pin levels, the enabled mask,
// the stored duty of the addressed channel and the PWM phase, all taken
// after that word's update.
// An input word is captured into an input register; once the output register
// is free, all of its work is done by one pass of combinational logic into the
// state and the output register. One word is accepted every cycle while the
// output side keeps taking words.
// When the receiver stalls, the output register holds its word and the input
// register holds the next one; in_stall rises only while both are full.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the idle
// level mask; a write changes no pin by itself and is taken while no word is
// waiting in the input register.
// Synchronous reset clears phase, enabled and active flags, pins, all duties
// and the idle mask, and empties both word registers.
module multichannel_soft_pwm_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire mspwm_pkg::in_word_t                in_word,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      mspwm_pkg::out_word_t               out_word,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [mspwm_pkg::CHANNELS-1:0]     cfg_data
);

  // Word registers.
  logic                  s1_valid_r;
  mspwm_pkg::in_word_t   s1_word_r;
  logic                  out_valid_r;
  mspwm_pkg::out_word_t  out_word_r;
  mspwm_pkg::out_word_t  out_word_nxt;

  // PWM state.
  mspwm_pkg::pwm_state_t                 pwm_r;
  mspwm_pkg::pwm_state_t                 pwm_nxt;
  mspwm_pkg::pwm_state_t                 tick_nxt;
  logic [mspwm_pkg::CHANNELS-1:0]        enabled_r;
  logic [mspwm_pkg::CHANNELS-1:0]        enabled_nxt;
  logic [mspwm_pkg::CHANNELS-1:0]        idle_mask_r;
  mspwm_pkg::duty_arr_t                  duty_r;
  mspwm_pkg::duty_arr_t                  duty_nxt;

  logic                                  advance;
  logic                                  in_accept;
  logic [mspwm_pkg::DUTY_W-1:0]          duty_sat;
  logic [mspwm_pkg::CH_W-1:0]            ch;
  logic                                  ch_on;

  // The word in the input register moves on whenever the output register is
  // empty or is being emptied in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  mspwm_tick_unit u_tick (
    .cur       (pwm_r),
    .enabled   (enabled_r),
    .idle_mask (idle_mask_r),
    .duties    (duty_r),
    .nxt       (tick_nxt)
  );

  // One pass of state update for the word in the input register.
  always_comb begin
    ch          = s1_word_r.channel;
    ch_on       = enabled_r[ch];
    duty_sat    = (s1_word_r.duty > mspwm_pkg::DUTY_MAX) ? mspwm_pkg::DUTY_MAX
                                                         : s1_word_r.duty;
    pwm_nxt     = pwm_r;
    enabled_nxt = enabled_r;
    duty_nxt    = duty_r;
    case (s1_word_r.func)
      mspwm_pkg::FN_TICK: begin
        pwm_nxt = tick_nxt;
      end
      mspwm_pkg::FN_ON: begin
        if (!ch_on) begin
          pwm_nxt.pins[ch]   = ~idle_mask_r[ch];
          pwm_nxt.active[ch] = 1'b0;
          enabled_nxt[ch]    = 1'b1;
        end
      end
      mspwm_pkg::FN_OFF: begin
        if (ch_on) begin
          pwm_nxt.pins[ch] = idle_mask_r[ch];
          enabled_nxt[ch]  = 1'b0;
        end
      end
      mspwm_pkg::FN_TOGGLE: begin
        if (ch_on) begin
          pwm_nxt.pins[ch] = idle_mask_r[ch];
          enabled_nxt[ch]  = 1'b0;
        end else begin
          pwm_nxt.pins[ch]   = ~idle_mask_r[ch];
          pwm_nxt.active[ch] = 1'b0;
          enabled_nxt[ch]    = 1'b1;
        end
      end
      mspwm_pkg::FN_SET_DUTY: begin
        duty_nxt[ch] = duty_sat;
      end
      default: begin
        // Read duty and unused codes leave the state alone.
      end
    endcase
    out_word_nxt.pin_levels   = pwm_nxt.pins;
    out_word_nxt.enabled_mask = enabled_nxt;
    out_word_nxt.duty_read    = duty_nxt[ch];
    out_word_nxt.phase        = pwm_nxt.phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pwm_r       <= '0;
      enabled_r   <= '0;
      idle_mask_r <= '0;
      duty_r      <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pwm_r       <= pwm_nxt;
        enabled_r   <= enabled_nxt;
        duty_r      <= duty_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        idle_mask_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    pwm_r.phase <= mspwm_pkg::PHASE_TOP)
    else $error("phase counter left its period");

  a_duty_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.duty_read <= mspwm_pkg::DUTY_MAX)
    else $error("stored duty above maximum");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free register");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_word_r == $past(out_word_nxt))
    else $error("advanced word did not reach the output register");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the multichannel soft PWM core: command words in, state words out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mspwm_pkg::*;

  // Function codes that the block has no operation for; they must leave all state alone.
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  localparam int RANDOM_PHASES  = 5;
  localparam int WORDS_PER_PASS = 245;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_word_t            in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CHANNELS-1:0] cfg_data  = '0;

  multichannel_soft_pwm_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the PWM state and the idle level register.
  logic [DUTY_W-1:0]   phase_q;
  logic [CHANNELS-1:0] enabled_q;
  logic [CHANNELS-1:0] active_q;
  logic [CHANNELS-1:0] pins_q;
  logic [CHANNELS-1:0] idle_mask_q;
  logic [DUTY_W-1:0]   duty_mem [CHANNELS];

  in_word_t    command_q [$];
  out_word_t   state_word_q [$];
  idle_style_t send_style = IDLE_SPARSE;
  idle_style_t recv_style = IDLE_SPARSE;
  int          mismatches = 0;
  int          hold_req   = 0;
  int          hold_ack   = 0;
  int          hold_left  = 0;

  function automatic int draw_wait(idle_style_t style);
    case (style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 16);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  // A pin shows the inverse of its idle level while the channel is active.
  function automatic void set_pin(int c, bit active);
    pins_q[c] = active ? ~idle_mask_q[c] : idle_mask_q[c];
  endfunction

  function automatic void pwm_switch_on(int c);
    if (!enabled_q[c]) begin
      set_pin(c, 1'b1);
      active_q[c]  = 1'b0;
      enabled_q[c] = 1'b1;
    end
  endfunction

  function automatic void pwm_switch_off(int c);
    if (enabled_q[c]) begin
      set_pin(c, 1'b0);
      enabled_q[c] = 1'b0;
    end
  endfunction

  // Applies one command to the shadow state and returns the state word it should produce.
  function automatic out_word_t pwm_apply(in_word_t w);
    out_word_t r;
    int        c;
    c = int'(w.channel);
    case (w.func)
      FN_TICK: begin
        phase_q = phase_q + 1'b1;
        if (phase_q >= PERIOD_STEPS) begin
          phase_q  = '0;
          active_q = '0;
        end
        // Pins are only rewritten when a channel's active flag flips.
        for (int k = 0; k < CHANNELS; k++) begin
          if (enabled_q[k]) begin
            if (duty_mem[k] > phase_q) begin
              if (!active_q[k]) begin
                set_pin(k, 1'b1);
                active_q[k] = 1'b1;
              end
            end else if (active_q[k]) begin
              set_pin(k, 1'b0);
              active_q[k] = 1'b0;
            end
          end
        end
      end
      FN_ON:  pwm_switch_on(c);
      FN_OFF: pwm_switch_off(c);
      FN_TOGGLE: begin
        if (enabled_q[c]) pwm_switch_off(c);
        else pwm_switch_on(c);
      end
      FN_SET_DUTY: duty_mem[c] = (w.duty > DUTY_MAX) ? DUTY_MAX : w.duty;
      default: ;
    endcase
    r.pin_levels   = pins_q;
    r.enabled_mask = enabled_q;
    r.duty_read    = duty_mem[c];
    r.phase        = phase_q;
    return r;
  endfunction

  function automatic void check_field(string name, int expd, int got);
    if (expd != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, expd, got);
    end
  endfunction

  // Sender: takes command words from the queue, with a drawn gap before each next word.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        state_word_q.push_back(pwm_apply(in_word));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (command_q.size() > 0) begin
          in_word  <= command_q.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_wait(send_style);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each state word and stalls for a drawn number of cycles after it.
  int recv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (state_word_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: state word 0x%0h arrived with none expected", $realtime, out_word);
        end else begin
          out_word_t expd;
          expd = state_word_q.pop_front();
          check_field("pin_levels", expd.pin_levels, out_word.pin_levels);
          check_field("enabled_mask", expd.enabled_mask, out_word.enabled_mask);
          check_field("duty_read", expd.duty_read, out_word.duty_read);
          check_field("phase", expd.phase, out_word.phase);
        end
        recv_gap = draw_wait(recv_style);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started by bumping hold_req; the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_cmd(logic [2:0] func, int ch, int duty);
    in_word_t w;
    w.func    = func;
    w.channel = CH_W'(ch);
    w.duty    = DUTY_W'(duty);
    command_q.push_back(w);
  endtask

  // Mostly ticks so that the phase wraps many times, with commands mixed in.
  task automatic queue_random_cmd();
    int          pick;
    logic [2:0]  func;
    pick = $urandom_range(0, 99);
    if (pick < 62)      func = FN_TICK;
    else if (pick < 72) func = FN_ON;
    else if (pick < 79) func = FN_OFF;
    else if (pick < 86) func = FN_TOGGLE;
    else if (pick < 94) func = FN_SET_DUTY;
    else if (pick < 98) func = FN_READ_DUTY;
    else                func = ($urandom_range(0, 1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
    queue_cmd(func, $urandom_range(0, CHANNELS - 1),
              ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (command_q.size() != 0 || in_valid || state_word_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The register is only written while nothing is in flight.
  task automatic write_idle_mask(logic [CHANNELS-1:0] value);
    @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid   <= 1'b0;
    idle_mask_q = value;
  endtask

  logic [CHANNELS-1:0] pass_masks [RANDOM_PHASES];
  idle_style_t         send_styles [RANDOM_PHASES];
  idle_style_t         recv_styles [RANDOM_PHASES];

  initial begin
    phase_q     = '0;
    enabled_q   = '0;
    active_q    = '0;
    pins_q      = '0;
    idle_mask_q = '0;
    foreach (duty_mem[k]) duty_mem[k] = '0;
    pass_masks  = '{8'hFF, 8'hA5, 8'h00, 8'h00, 8'h5A};
    pass_masks[2] = CHANNELS'($urandom_range(0, 255));
    send_styles = '{IDLE_FULL, IDLE_SPARSE, IDLE_NONE, IDLE_NONE, IDLE_FULL};
    recv_styles = '{IDLE_FULL, IDLE_FULL, IDLE_SPARSE, IDLE_NONE, IDLE_SPARSE};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: saturation, zero duty, redundant on and off, toggles, spare codes.
    write_idle_mask('0);
    queue_cmd(FN_SET_DUTY, 0, 100);
    queue_cmd(FN_SET_DUTY, 1, 0);
    queue_cmd(FN_SET_DUTY, 2, 127);
    queue_cmd(FN_SET_DUTY, 7, 101);
    queue_cmd(FN_READ_DUTY, 2, 0);
    queue_cmd(FN_READ_DUTY, 7, 127);
    queue_cmd(FN_ON, 0, 0);
    queue_cmd(FN_ON, 1, 0);
    queue_cmd(FN_ON, 0, 55);
    queue_cmd(FN_OFF, 4, 0);
    queue_cmd(FN_TOGGLE, 7, 0);
    queue_cmd(FN_TOGGLE, 2, 0);
    queue_cmd(FN_TOGGLE, 2, 0);
    queue_cmd(FN_TICK, 7, 127);
    queue_cmd(FN_TICK, 0, 0);
    queue_cmd(FN_SPARE_LO, 3, 42);
    queue_cmd(FN_SPARE_HI, 7, 127);
    queue_cmd(FN_SET_DUTY, 3, 1);
    queue_cmd(FN_ON, 3, 0);
    queue_cmd(FN_TICK, 0, 0);
    queue_cmd(FN_OFF, 1, 0);
    queue_cmd(FN_OFF, 7, 0);
    queue_cmd(FN_SET_DUTY, 5, 99);
    queue_cmd(FN_ON, 5, 0);
    queue_cmd(FN_READ_DUTY, 5, 0);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_idle_mask(pass_masks[p]);
      send_style = send_styles[p];
      recv_style = recv_styles[p];
      // In the third pass the receiver holds off while the sender streams words back to back.
      if (p == 2) hold_req++;
      for (int n = 0; n < WORDS_PER_PASS; n++) queue_random_cmd();
      wait_drained();
    end

    if (mismatches == 0 && state_word_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mspwm_pkg.sv
src/mspwm_tick_unit.sv
src/multichannel_soft_pwm_core.sv
test/tb_top.sv
